// ===== src/asl_pkg.sv =====
// Shared types and constants for the line-boundary access splitter.
// Used by asl_ctrl, asl_datapath and the top level; depends on nothing.
`default_nettype none

package asl_pkg;

   localparam int LINE_BYTES_DEF       = 64;
   localparam int MAX_ACCESS_BYTES_DEF = 64;

   localparam int TID_W   = 8;
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 7;
   localparam int CHUNK_W = 4;
   localparam int TOTAL_W = 48;

   // No access produces more chunks than this.
   localparam int RESULT_LIMIT = 20;
   localparam int CNT_W        = $clog2(RESULT_LIMIT);

   localparam logic [CHUNK_W-1:0] CHUNK_8 = 4'd8;
   localparam logic [CHUNK_W-1:0] CHUNK_4 = 4'd4;
   localparam logic [CHUNK_W-1:0] CHUNK_2 = 4'd2;
   localparam logic [CHUNK_W-1:0] CHUNK_1 = 4'd1;

   typedef struct packed {
      logic [TID_W-1:0]  thread_id;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size_bytes;
   } req_type;

   typedef struct packed {
      logic [TID_W-1:0]   thread_out;
      logic [ADDR_W-1:0]  chunk_address;
      logic [CHUNK_W-1:0] chunk_size;
      logic               last_chunk;
      logic [TOTAL_W-1:0] total_chunks;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic empty_access;
      logic chunk_last;
   } status_type;

endpackage

`default_nettype wire

// ===== src/asl_ctrl.sv =====
// Controller for the line-boundary access splitter: accepts an access and
// sequences one chunk per free output slot. Depends on asl_pkg.
`default_nettype none

module asl_ctrl
   import asl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   // The output register can take a new word when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load = 1'b0;
      cmd.emit = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.empty_access) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               if (status.chunk_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/asl_datapath.sv =====
// Datapath for the line-boundary access splitter: part lengths, chunk
// address, running chunk total and the output word. Depends on asl_pkg.
`default_nettype none

module asl_datapath
   import asl_pkg::*;
#(
   parameter int LINE_BYTES       = LINE_BYTES_DEF,
   parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output status_type   status,
   output rsp_type      rsp_data
);

   // LINE_BYTES must be a power of two (unchecked); offset = low address bits.
   localparam int OFF_W = $clog2(LINE_BYTES);
   localparam int LEN_W = $clog2(LINE_BYTES + MAX_ACCESS_BYTES + (1 << SIZE_W));
   localparam logic [LEN_W-1:0] LINE_LEN = LEN_W'(LINE_BYTES);
   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_ACCESS_BYTES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULT_LIMIT - 1);

   logic [TID_W-1:0]   tid_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [LEN_W-1:0]   part_ff, part_in;
   logic [LEN_W-1:0]   trail_ff, trail_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TOTAL_W-1:0] total_ff, total_next;
   rsp_type            rsp_ff;

   logic [LEN_W-1:0]   size_ext, size_sat, offset, end_pos;
   logic [CHUNK_W-1:0] chunk;
   logic [LEN_W-1:0]   part_left;
   logic               last;

   assign status.empty_access = (req_data.size_bytes == '0);
   assign status.chunk_last   = last;
   assign rsp_data            = rsp_ff;

   always_comb begin
      size_ext = LEN_W'(req_data.size_bytes);
      size_sat = (size_ext > MAX_LEN) ? MAX_LEN : size_ext;
      offset   = LEN_W'(req_data.address[OFF_W-1:0]);
      end_pos  = offset + size_sat;
      if (end_pos > LINE_LEN) begin
         part_in  = LINE_LEN - offset;
         trail_in = end_pos - LINE_LEN;
      end else begin
         part_in  = size_sat;
         trail_in = '0;
      end
   end

   // Greedy chunking: largest of 8, 4, 2, 1 that still fits the part.
   always_comb begin
      priority if (part_ff >= LEN_W'(8)) begin
         chunk = CHUNK_8;
      end else if (part_ff >= LEN_W'(4)) begin
         chunk = CHUNK_4;
      end else if (part_ff >= LEN_W'(2)) begin
         chunk = CHUNK_2;
      end else begin
         chunk = CHUNK_1;
      end
      part_left  = part_ff - LEN_W'(chunk);
      total_next = total_ff + TOTAL_W'(1);
      last       = ((part_left == '0) && (trail_ff == '0)) || (cnt_ff == CNT_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.emit) begin
         total_ff <= total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tid_ff   <= req_data.thread_id;
         addr_ff  <= req_data.address;
         part_ff  <= part_in;
         trail_ff <= trail_in;
         cnt_ff   <= '0;
      end else if (cmd.emit) begin
         addr_ff <= addr_ff + ADDR_W'(chunk);
         cnt_ff  <= cnt_ff + CNT_W'(1);
         if (part_left == '0) begin
            part_ff  <= trail_ff;
            trail_ff <= '0;
         end else begin
            part_ff <= part_left;
         end
      end
      if (cmd.emit) begin
         rsp_ff.thread_out    <= tid_ff;
         rsp_ff.chunk_address <= addr_ff;
         rsp_ff.chunk_size    <= chunk;
         rsp_ff.last_chunk    <= last;
         rsp_ff.total_chunks  <= total_next;
      end
   end

endmodule

`default_nettype wire

// ===== src/access_splitter_at_line_boundary.sv =====
// Line-boundary access splitter, top level. An accepted access is loaded into
// the datapath, which then yields one chunk word per cycle while the output is
// not stalled, up to twenty chunks, sequenced by the controller. A new access
// is taken only after the last chunk is issued; each word is registered.
// Reset clears the controller and the running chunk total.
`default_nettype none

module access_splitter_at_line_boundary
   import asl_pkg::*;
#(
   parameter int LINE_BYTES       = LINE_BYTES_DEF,
   parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   asl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   asl_datapath #(
      .LINE_BYTES       (LINE_BYTES),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_access_splitter_at_line_boundary.sv =====
// Self-checking testbench for the line-boundary access splitter: a directed
// table of accesses followed by random ones, with random idling on both sides.
// Depends on asl_pkg and access_splitter_at_line_boundary.
`default_nettype none

module tb_access_splitter_at_line_boundary;
   import asl_pkg::*;

   localparam int LINE      = LINE_BYTES_DEF;
   localparam int MAX_BYTES = MAX_ACCESS_BYTES_DEF;
   localparam int RANDOM_ACCESSES = 210;
   localparam int LONG_HOLD = 400;

   typedef struct {
      req_type access;
      bit      typed;
      int      typed_count;
      rsp_type typed_chunk;
   } access_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [TOTAL_W-1:0] chunk_count = '0;
   rsp_type access_chunks[$];
   rsp_type expected_chunks[$];
   access_row_type directed[$];
   int accepted_accesses = 0;
   int mismatches = 0;
   bit no_idle = 1'b0;

   access_splitter_at_line_boundary dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("access_splitter_at_line_boundary test failed");
      $finish;
   end

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // Cuts a run of bytes greedily into 8, 4, 2 and 1 byte chunks.
   function automatic void chunk_run(input int unsigned len, input logic [TID_W-1:0] tid,
                                     inout logic [ADDR_W-1:0] at);
      int unsigned step;
      rsp_type c;
      for (step = 8; step > 0; step = step >> 1) begin
         while (len >= step && access_chunks.size() < RESULT_LIMIT) begin
            chunk_count     = chunk_count + 1'b1;
            c.thread_out    = tid;
            c.chunk_address = at;
            c.chunk_size    = CHUNK_W'(step);
            c.last_chunk    = 1'b0;
            c.total_chunks  = chunk_count;
            access_chunks.push_back(c);
            at  = at + ADDR_W'(step);
            len = len - step;
         end
      end
   endfunction

   function automatic void split_access(input req_type r);
      int unsigned size, offset;
      logic [ADDR_W-1:0] at;
      access_chunks.delete();
      size = 32'(r.size_bytes);
      if (size > MAX_BYTES)
         size = MAX_BYTES;
      if (size == 0)
         return;
      at     = r.address;
      offset = int'(r.address % LINE);
      // Only the first line mark counts; the rest is chunked as one piece.
      if (offset + size > LINE) begin
         chunk_run(LINE - offset, r.thread_id, at);
         chunk_run(offset + size - LINE, r.thread_id, at);
      end else begin
         chunk_run(size, r.thread_id, at);
      end
      if (access_chunks.size() > 0)
         access_chunks[access_chunks.size() - 1].last_chunk = 1'b1;
   endfunction

   function automatic req_type random_access();
      req_type r;
      int pick;
      r.thread_id = TID_W'($urandom);
      r.address   = {$urandom, $urandom};
      // Many accesses start close to the end of a line so that they get cut.
      if ($urandom_range(0, 99) < 45)
         r.address[5:0] = 6'(LINE - $urandom_range(1, 12));
      pick = $urandom_range(0, 99);
      if (pick < 5)
         r.size_bytes = '0;
      else if (pick < 12)
         r.size_bytes = SIZE_W'($urandom_range(MAX_BYTES + 1, 127));
      else
         r.size_bytes = SIZE_W'($urandom_range(1, MAX_BYTES));
      return r;
   endfunction

   task automatic offer_access(input req_type r, input bit typed, input int typed_count,
                               input rsp_type typed_chunk);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      accepted_accesses++;
      // The predicted state advances on every row, typed ones included.
      split_access(r);
      if (typed) begin
         for (int k = 0; k < typed_count; k++)
            expected_chunks.push_back(typed_chunk);
      end else begin
         foreach (access_chunks[k])
            expected_chunks.push_back(access_chunks[k]);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chunks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected chunk word: tid %h addr %h size %0d last %b total %0d",
                        rsp_data.thread_out, rsp_data.chunk_address, rsp_data.chunk_size,
                        rsp_data.last_chunk, rsp_data.total_chunks);
         end else begin
            want = expected_chunks.pop_front();
            if (rsp_data.thread_out !== want.thread_out ||
                rsp_data.chunk_address !== want.chunk_address ||
                rsp_data.chunk_size !== want.chunk_size ||
                rsp_data.last_chunk !== want.last_chunk ||
                rsp_data.total_chunks !== want.total_chunks) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"chunk word mismatch: expected tid %h addr %h size %0d last %b ",
                            "total %0d, got tid %h addr %h size %0d last %b total %0d"},
                           want.thread_out, want.chunk_address, want.chunk_size,
                           want.last_chunk, want.total_chunks, rsp_data.thread_out,
                           rsp_data.chunk_address, rsp_data.chunk_size, rsp_data.last_chunk,
                           rsp_data.total_chunks);
            end
         end
      end
   end

   // Result side: random stall before each word, and one long hold-off that
   // lets the splitter fill up and push back on its input.
   initial begin
      int hold;
      bit long_done;
      long_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = idle_draw();
         if (!long_done && accepted_accesses >= 40) begin
            hold      = LONG_HOLD;
            long_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      int waited;
      // Rows with a typed expectation come first, while the running total is
      // still easy to follow from reset.
      directed.push_back('{'{8'h00, 64'h0, 7'd8}, 1'b1, 1,
                           '{8'h00, 64'h0, CHUNK_8, 1'b1, 48'd1}});
      directed.push_back('{'{8'h00, 64'h0, 7'd0}, 1'b1, 0, '0});
      directed.push_back('{'{8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1}, 1'b1, 1,
                           '{8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHUNK_1, 1'b1, 48'd2}});
      directed.push_back('{'{8'h5A, 64'h40, 7'd8}, 1'b1, 1,
                           '{8'h5A, 64'h40, CHUNK_8, 1'b1, 48'd3}});
      directed.push_back('{'{8'h01, 64'h3E, 7'd2}, 1'b1, 1,
                           '{8'h01, 64'h3E, CHUNK_2, 1'b1, 48'd4}});
      directed.push_back('{'{8'h80, 64'h3C, 7'd4}, 1'b1, 1,
                           '{8'h80, 64'h3C, CHUNK_4, 1'b1, 48'd5}});
      directed.push_back('{'{8'h11, 64'h0, 7'd64}, 1'b0, 0, '0});
      directed.push_back('{'{8'h22, 64'h1, 7'd64}, 1'b0, 0, '0});
      directed.push_back('{'{8'h33, 64'h3F, 7'd64}, 1'b0, 0, '0});
      directed.push_back('{'{8'h44, 64'h20, 7'd127}, 1'b0, 0, '0});
      directed.push_back('{'{8'h55, 64'h0, 7'd65}, 1'b0, 0, '0});
      directed.push_back('{'{8'h66, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0}, 1'b0, 0, '0});
      directed.push_back('{'{8'h77, 64'hFFFF_FFFF_FFFF_FFFC, 7'd8}, 1'b0, 0, '0});
      directed.push_back('{'{8'h88, 64'hFFFF_FFFF_FFFF_FFC1, 7'd64}, 1'b0, 0, '0});
      directed.push_back('{'{8'h99, 64'h38, 7'd15}, 1'b0, 0, '0});
      directed.push_back('{'{8'hA5, 64'h10, 7'd7}, 1'b0, 0, '0});
      directed.push_back('{'{8'hB6, 64'h3F, 7'd3}, 1'b0, 0, '0});
      directed.push_back('{'{8'hC7, 64'h5555_5555_5555_5555, 7'd63}, 1'b0, 0, '0});
      directed.push_back('{'{8'hD8, 64'h1000_0000_0000_0027, 7'd40}, 1'b0, 0, '0});
      directed.push_back('{'{8'hAA, 64'hFFFF_FFFF_FFFF_FFC0, 7'd64}, 1'b0, 0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         offer_access(directed[i].access, directed[i].typed, directed[i].typed_count,
                      directed[i].typed_chunk);

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         no_idle = (n >= 140 && n < 175);
         // Let the splitter drain completely once before going on.
         if (n == 100) begin
            req_valid <= 1'b0;
            while (expected_chunks.size() != 0) @(posedge clock);
         end
         offer_access(random_access(), 1'b0, 0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (expected_chunks.size() != 0) @(posedge clock);
      waited = 0;
      while (waited < 24) begin
         @(posedge clock);
         waited++;
      end
      if (mismatches == 0 && expected_chunks.size() == 0) begin
         $display("access_splitter_at_line_boundary test passed");
      end else begin
         $display("access_splitter_at_line_boundary test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
